// ===== rtl/core/sgdmf_pkg.sv =====
// sgdmf_pkg: shared types, codes and saturation helper for the sgd factorization core
// depends on nothing; used by the channel interfaces and every core module
package sgdmf_pkg;

    localparam int ELEM_W    = 16;
    localparam int CSR_IDX_W = 2;
    localparam int ACC_W     = 56;

    typedef logic signed [ELEM_W-1:0] elem_t;

    localparam logic [2:0] OP_TRAIN   = 3'd0;
    localparam logic [2:0] OP_WR_USER = 3'd1;
    localparam logic [2:0] OP_WR_ITEM = 3'd2;
    localparam logic [2:0] OP_RD_USER = 3'd3;
    localparam logic [2:0] OP_RD_ITEM = 3'd4;

    localparam logic [CSR_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [CSR_IDX_W-1:0] REG_REG_LAMBDA = 2'd1;

    localparam logic [15:0] LEARN_RATE_RST = 16'd655;
    localparam logic [15:0] REG_LAMBDA_RST = 16'd1311;

    typedef struct packed {
        logic  flag;
        elem_t value;
    } sat_t;

    function automatic sat_t sat16(input logic signed [31:0] v);
        sat_t r;
        if (v > 32'sd32767)
        begin
            r.flag  = 1'b1;
            r.value = 16'sh7fff;
        end
        else if (v < -32'sd32768)
        begin
            r.flag  = 1'b1;
            r.value = 16'sh8000;
        end
        else
        begin
            r.flag  = 1'b0;
            r.value = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sgdmf_if.sv =====
// sgdmf channel interfaces: request, response and register write words
// depends on sgdmf_pkg
interface sgdmf_req_if;
    import sgdmf_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [9:0]  user_index;
    logic [9:0]  item_index;
    logic [4:0]  element_index;
    elem_t       load_value;
    elem_t       rating;
    logic        end_of_pass;

    modport source (output valid, operation, user_index, item_index, element_index,
                    load_value, rating, end_of_pass, input ready);
    modport sink   (input valid, operation, user_index, item_index, element_index,
                    load_value, rating, end_of_pass, output ready);
endinterface

interface sgdmf_rsp_if;
    import sgdmf_pkg::*;
    logic  valid;
    logic  ready;
    elem_t result_value;
    logic  saturated;
    logic  pass_done;

    modport source (output valid, result_value, saturated, pass_done, input ready);
    modport sink   (input valid, result_value, saturated, pass_done, output ready);
endinterface

interface sgdmf_csr_if;
    import sgdmf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CSR_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sgdmf_ram.sv =====
// sgdmf_ram: factor table, one write port and one read port, registered read data
// depends on sgdmf_pkg
module sgdmf_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  sgdmf_pkg::elem_t  wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output sgdmf_pkg::elem_t  rdata
);
    import sgdmf_pkg::*;

    elem_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/sgdmf_dot.sv =====
// sgdmf_dot: multiply stage and accumulator for the row dot product
// depends on sgdmf_pkg
module sgdmf_dot #(
    parameter int DOT_W = 37
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  logic                    in_valid,
    input  sgdmf_pkg::elem_t        a,
    input  sgdmf_pkg::elem_t        b,
    output logic                    busy,
    output logic signed [DOT_W-1:0] sum
);
    import sgdmf_pkg::*;

    logic                    pv_reg;
    logic signed [31:0]      prod_reg;
    logic signed [DOT_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + DOT_W'(prod_reg);
        end
    end

    assign busy = pv_reg;
    assign sum  = acc_reg;

endmodule

// ===== rtl/core/sgdmf_upd.sv =====
// sgdmf_upd: two-stage element update, x*scale plus step*residual*y, rounded and clipped
// depends on sgdmf_pkg
module sgdmf_upd (
    input  logic               clk,
    input  sgdmf_pkg::elem_t   x,
    input  sgdmf_pkg::elem_t   y,
    input  logic [31:0]        sl,
    input  logic signed [32:0] sr,
    output sgdmf_pkg::elem_t   z,
    output logic               sat
);
    import sgdmf_pkg::*;

    logic signed [48:0]      p1_reg;
    logic signed [48:0]      p2_reg;
    elem_t                   x_reg;
    logic signed [ACC_W-1:0] acc;
    logic signed [23:0]      shifted;
    sat_t                    clip;
    sat_t                    out_reg;

    always_comb
    begin
        acc = {{(ACC_W-48){x_reg[15]}}, x_reg, 32'b0}
            - {{(ACC_W-49){p1_reg[48]}}, p1_reg}
            + {{(ACC_W-53){p2_reg[48]}}, p2_reg, 4'b0}
            + ACC_W'(64'h8000_0000);
        shifted = acc[ACC_W-1:32];
        clip    = sat16(32'(shifted));
    end

    always_ff @(posedge clk)
    begin
        p1_reg  <= x * $signed({1'b0, sl});
        p2_reg  <= sr * y;
        x_reg   <= x;
        out_reg <= clip;
    end

    assign z   = out_reg.value;
    assign sat = out_reg.flag;

endmodule

// ===== rtl/core/sgd_matrix_factorization_step.sv =====
// sgd_matrix_factorization_step: top level, sequencer around the user and item factor memories
// depends on sgdmf_pkg, sgdmf_if, sgdmf_ram, sgdmf_dot, sgdmf_upd
//
//  channel   kind      word
//  req       sink      operation, user_index, item_index, element_index, load_value, rating,
//                      end_of_pass
//  rsp       source    result_value, saturated, pass_done
//  csr       sink      index, data (0 learning rate, 1 reg_lambda)
//
// train: one dot pass and one update pass through the single read port of each factor
// memory, states ST_START, ST_DOT, ST_DOT_DRAIN, ST_RES, ST_SR, ST_UPD, ST_UPD_DRAIN, ST_FIN
// read: ST_START, ST_RDWAIT, ST_FIN; write and ignored words: ST_START, ST_FIN
// one word in flight; rsp is a register, so a new word is taken while a response waits
// reset clears control and registers only; table contents are undefined until loaded
module sgd_matrix_factorization_step #(
    parameter int NUM_USERS = 1024,
    parameter int NUM_ITEMS = 1024,
    parameter int RANK      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sgdmf_req_if.sink   req,
    sgdmf_rsp_if.source rsp,
    sgdmf_csr_if.sink   csr
);
    import sgdmf_pkg::*;

    localparam int U_DEPTH = NUM_USERS * RANK;
    localparam int I_DEPTH = NUM_ITEMS * RANK;
    localparam int UA_W    = (U_DEPTH > 1) ? $clog2(U_DEPTH) : 1;
    localparam int IA_W    = (I_DEPTH > 1) ? $clog2(I_DEPTH) : 1;
    localparam int K_W     = (RANK > 1) ? $clog2(RANK) : 1;
    localparam int DOT_W   = 32 + $clog2(RANK);

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_RDWAIT, ST_DOT, ST_DOT_DRAIN,
        ST_RES, ST_SR, ST_UPD, ST_UPD_DRAIN, ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               rv_dot_reg, rv_dot_next;
    logic [4:0]         vp_reg, vp_next;
    logic [15:0]        step_reg, step_next;
    logic [15:0]        lambda_reg, lambda_next;
    logic [2:0]         op_reg, op_next;
    logic [9:0]         ui_reg, ui_next;
    logic [9:0]         ii_reg, ii_next;
    logic [4:0]         ei_reg, ei_next;
    elem_t              load_reg, load_next;
    elem_t              rating_reg, rating_next;
    logic               eop_reg, eop_next;
    elem_t              res_reg, res_next;
    logic               sat_reg, sat_next;
    logic               done_reg, done_next;
    logic [31:0]        sl_reg, sl_next;
    logic signed [32:0] sr_reg, sr_next;
    logic [UA_W-1:0]    u_base_reg, u_base_next;
    logic [IA_W-1:0]    i_base_reg, i_base_next;
    logic               out_valid_reg, out_valid_next;
    elem_t              out_value_reg, out_value_next;
    logic               out_sat_reg, out_sat_next;
    logic               out_done_reg, out_done_next;

    logic [K_W-1:0]     idx_pipe_reg [5];
    elem_t              vd1_reg;
    elem_t              vd2_reg;

    logic               u_ok, i_ok, e_ok;
    logic [UA_W-1:0]    u_elem_addr, u_row_addr;
    logic [IA_W-1:0]    i_elem_addr, i_row_addr;
    logic               u_we, u_re, i_we, i_re;
    logic [UA_W-1:0]    u_waddr, u_raddr;
    logic [IA_W-1:0]    i_waddr, i_raddr;
    elem_t              u_wdata, i_wdata, u_rdata, i_rdata;
    logic               dot_busy;
    logic signed [DOT_W-1:0] dot_sum;
    logic signed [DOT_W:0]   dot_rnd;
    logic signed [DOT_W+1:0] resid_wide;
    sat_t               resid;
    elem_t              u_new, i_new;
    logic               u_sat, i_sat;

    assign u_ok        = 32'(ui_reg) < NUM_USERS;
    assign i_ok        = 32'(ii_reg) < NUM_ITEMS;
    assign e_ok        = 32'(ei_reg) < RANK;
    assign u_row_addr  = UA_W'(32'(ui_reg) * RANK);
    assign i_row_addr  = IA_W'(32'(ii_reg) * RANK);
    assign u_elem_addr = UA_W'(32'(ui_reg) * RANK + 32'(ei_reg));
    assign i_elem_addr = IA_W'(32'(ii_reg) * RANK + 32'(ei_reg));

    always_comb
    begin
        dot_rnd    = ((DOT_W+1)'(dot_sum) + (DOT_W+1)'(2048)) >>> 12;
        resid_wide = (DOT_W+2)'(rating_reg) - (DOT_W+2)'(dot_rnd);
        resid      = sat16(32'(resid_wide));
    end

    // memory ports
    always_comb
    begin
        u_re    = 1'b0;
        i_re    = 1'b0;
        u_raddr = u_base_reg + UA_W'(k_reg);
        i_raddr = i_base_reg + IA_W'(k_reg);
        case (state_reg)
            ST_START:
            begin
                u_raddr = u_elem_addr;
                i_raddr = i_elem_addr;
                u_re    = (op_reg == OP_RD_USER);
                i_re    = (op_reg == OP_RD_ITEM);
            end
            ST_DOT, ST_UPD:
            begin
                u_re = 1'b1;
                i_re = 1'b1;
            end
            default:
            begin
                u_re = 1'b0;
                i_re = 1'b0;
            end
        endcase

        if (state_reg == ST_START)
        begin
            u_we    = (op_reg == OP_WR_USER) && u_ok && e_ok;
            i_we    = (op_reg == OP_WR_ITEM) && i_ok && e_ok;
            u_waddr = u_elem_addr;
            i_waddr = i_elem_addr;
            u_wdata = load_reg;
            i_wdata = load_reg;
        end
        else
        begin
            u_we    = vp_reg[2];
            i_we    = vp_reg[4];
            u_waddr = u_base_reg + UA_W'(idx_pipe_reg[2]);
            i_waddr = i_base_reg + IA_W'(idx_pipe_reg[4]);
            u_wdata = u_new;
            i_wdata = i_new;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        rv_dot_next    = (state_reg == ST_DOT);
        vp_next        = {vp_reg[3:0], state_reg == ST_UPD};
        step_next      = step_reg;
        lambda_next    = lambda_reg;
        op_next        = op_reg;
        ui_next        = ui_reg;
        ii_next        = ii_reg;
        ei_next        = ei_reg;
        load_next      = load_reg;
        rating_next    = rating_reg;
        eop_next       = eop_reg;
        res_next       = res_reg;
        sat_next       = sat_reg;
        done_next      = done_reg;
        sl_next        = sl_reg;
        sr_next        = sr_reg;
        u_base_next    = u_base_reg;
        i_base_next    = i_base_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        out_done_next  = out_done_reg;

        if (csr.valid)
        begin
            case (csr.index)
                REG_LEARN_RATE: step_next   = csr.data;
                REG_REG_LAMBDA: lambda_next = csr.data;
                default:        step_next   = step_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.operation;
                    ui_next     = req.user_index;
                    ii_next     = req.item_index;
                    ei_next     = req.element_index;
                    load_next   = req.load_value;
                    rating_next = req.rating;
                    eop_next    = req.end_of_pass;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                res_next    = '0;
                sat_next    = 1'b0;
                done_next   = 1'b0;
                u_base_next = u_row_addr;
                i_base_next = i_row_addr;
                k_next      = '0;
                state_next  = ST_FIN;
                case (op_reg)
                    OP_TRAIN:
                    begin
                        done_next = eop_reg;
                        sl_next   = step_reg * lambda_reg;
                        if (u_ok && i_ok)
                        begin
                            state_next = ST_DOT;
                        end
                    end
                    OP_RD_USER:
                    begin
                        if (u_ok && e_ok)
                        begin
                            state_next = ST_RDWAIT;
                        end
                    end
                    OP_RD_ITEM:
                    begin
                        if (i_ok && e_ok)
                        begin
                            state_next = ST_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                res_next   = (op_reg == OP_RD_USER) ? u_rdata : i_rdata;
                state_next = ST_FIN;
            end
            ST_DOT:
            begin
                k_next = k_reg + K_W'(1);
                if (k_reg == K_W'(RANK - 1))
                begin
                    k_next     = '0;
                    state_next = ST_DOT_DRAIN;
                end
            end
            ST_DOT_DRAIN:
            begin
                if (!rv_dot_reg && !dot_busy)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                res_next   = resid.value;
                sat_next   = resid.flag;
                state_next = ST_SR;
            end
            ST_SR:
            begin
                sr_next    = $signed({1'b0, step_reg}) * res_reg;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                sat_next = sat_reg | (vp_reg[2] & u_sat) | (vp_reg[4] & i_sat);
                k_next   = k_reg + K_W'(1);
                if (k_reg == K_W'(RANK - 1))
                begin
                    k_next     = '0;
                    state_next = ST_UPD_DRAIN;
                end
            end
            ST_UPD_DRAIN:
            begin
                sat_next = sat_reg | (vp_reg[2] & u_sat) | (vp_reg[4] & i_sat);
                if (vp_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_sat_next   = sat_reg;
                    out_done_next  = done_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            rv_dot_reg    <= 1'b0;
            vp_reg        <= '0;
            step_reg      <= LEARN_RATE_RST;
            lambda_reg    <= REG_LAMBDA_RST;
            op_reg        <= OP_TRAIN;
            ui_reg        <= '0;
            ii_reg        <= '0;
            ei_reg        <= '0;
            load_reg      <= '0;
            rating_reg    <= '0;
            eop_reg       <= 1'b0;
            res_reg       <= '0;
            sat_reg       <= 1'b0;
            done_reg      <= 1'b0;
            sl_reg        <= '0;
            sr_reg        <= '0;
            u_base_reg    <= '0;
            i_base_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_sat_reg   <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            rv_dot_reg    <= rv_dot_next;
            vp_reg        <= vp_next;
            step_reg      <= step_next;
            lambda_reg    <= lambda_next;
            op_reg        <= op_next;
            ui_reg        <= ui_next;
            ii_reg        <= ii_next;
            ei_reg        <= ei_next;
            load_reg      <= load_next;
            rating_reg    <= rating_next;
            eop_reg       <= eop_next;
            res_reg       <= res_next;
            sat_reg       <= sat_next;
            done_reg      <= done_next;
            sl_reg        <= sl_next;
            sr_reg        <= sr_next;
            u_base_reg    <= u_base_next;
            i_base_reg    <= i_base_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
            out_done_reg  <= out_done_next;
        end
    end

    // element index and partner value alongside the update pipeline
    always_ff @(posedge clk)
    begin
        idx_pipe_reg[0] <= k_reg;
        for (int i = 1; i < 5; i++)
        begin
            idx_pipe_reg[i] <= idx_pipe_reg[i-1];
        end
        vd1_reg <= i_rdata;
        vd2_reg <= vd1_reg;
    end

    sgdmf_ram #(.DEPTH(U_DEPTH), .AW(UA_W)) u_user_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (u_re),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    sgdmf_ram #(.DEPTH(I_DEPTH), .AW(IA_W)) u_item_ram (
        .clk   (clk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .re    (i_re),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    sgdmf_dot #(.DOT_W(DOT_W)) u_dot (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (state_reg == ST_START),
        .in_valid (rv_dot_reg),
        .a        (u_rdata),
        .b        (i_rdata),
        .busy     (dot_busy),
        .sum      (dot_sum)
    );

    sgdmf_upd u_upd_user (
        .clk (clk),
        .x   (u_rdata),
        .y   (i_rdata),
        .sl  (sl_reg),
        .sr  (sr_reg),
        .z   (u_new),
        .sat (u_sat)
    );

    sgdmf_upd u_upd_item (
        .clk (clk),
        .x   (vd2_reg),
        .y   (u_new),
        .sl  (sl_reg),
        .sr  (sr_reg),
        .z   (i_new),
        .sat (i_sat)
    );

    assign req.ready        = (state_reg == ST_IDLE);
    assign csr.ready        = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.saturated    = out_sat_reg;
    assign rsp.pass_done    = out_done_reg;

    // no writeback while the dot pass still reads the rows
    a_no_write_in_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DOT || state_reg == ST_DOT_DRAIN) |-> (!u_we && !i_we))
        else $error("factor write during dot pass");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_START))
        else $error("accepted word did not start");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (vp_reg == '0 && !rv_dot_reg && !dot_busy))
        else $error("pipeline busy while idle");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && (!out_valid_reg || rsp.ready)) |=> out_valid_reg)
        else $error("finished word not presented");

    a_upd_only_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        vp_reg[0] |-> $past(state_reg == ST_UPD))
        else $error("update pipeline entry outside update pass");

endmodule
